// ----- rtl/ifcm_pkg.sv -----
// ifcm_pkg: shared constants, types and segment tables of the false-color map
// no dependencies; used by the channel interfaces and every rtl module
`timescale 1ns / 1ps
package ifcm_pkg;

   localparam int INTENSITY_W             = 16;
   localparam int COLOR_W                 = 8;
   localparam int INTENSITY_FRAC_BITS_DEF = 14;

   localparam int NUM_SEGS    = 7;
   localparam int NUM_CH      = 3;
   localparam int CH_RED      = 0;
   localparam int CH_GREEN    = 1;
   localparam int CH_BLUE     = 2;
   localparam int SEG_W       = $clog2(NUM_SEGS);
   localparam int POS_W       = 5;
   localparam int SPAN_W      = 3;
   localparam int SLOPE_W     = 9;
   localparam int BASE_SPAN_W = 10;
   localparam int SCALE_W     = 20;
   localparam int Q_W         = BASE_SPAN_W + 2;
   localparam int RECIP_W     = 21;
   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;

   typedef logic [SEG_W-1:0]          seg_idx_type;
   typedef logic [POS_W-1:0]          seg_pos_type;
   typedef logic [SPAN_W-1:0]         seg_span_type;
   typedef logic [COLOR_W-1:0]        color_type;
   typedef logic signed [SLOPE_W-1:0] slope_type;
   typedef logic [BASE_SPAN_W-1:0]    base_span_type;

   // segment start and width in twentieths of full scale
   localparam seg_pos_type SEG_START [NUM_SEGS] =
      '{5'd0, 5'd2, 5'd6, 5'd10, 5'd14, 5'd17, 5'd19};
   localparam seg_span_type SEG_SPAN [NUM_SEGS] =
      '{3'd2, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd1};

   // end colors: base plus slope over the segment, red / green / blue
   localparam color_type SEG_BASE [NUM_SEGS][NUM_CH] = '{
      '{8'd0,   8'd0,   8'd0},
      '{8'd0,   8'd20,  8'd30},
      '{8'd0,   8'd80,  8'd180},
      '{8'd80,  8'd160, 8'd255},
      '{8'd160, 8'd255, 8'd55},
      '{8'd255, 8'd255, 8'd0},
      '{8'd255, 8'd0,   8'd0}
   };
   localparam slope_type SEG_SLOPE [NUM_SEGS][NUM_CH] = '{
      '{ 9'sd0,   9'sd20,   9'sd30},
      '{ 9'sd0,   9'sd60,   9'sd150},
      '{ 9'sd80,  9'sd80,   9'sd75},
      '{ 9'sd80,  9'sd95,  -9'sd200},
      '{ 9'sd95,  9'sd0,   -9'sd55},
      '{ 9'sd0,  -9'sd128,  9'sd0},
      '{ 9'sd0,   9'sd0,    9'sd100}
   };

   function automatic base_span_type base_scaled(seg_idx_type seg, int ch);
      base_span_type r;
      r = base_span_type'(SEG_BASE[seg][ch]) * base_span_type'(SEG_SPAN[seg]);
      return r;
   endfunction

endpackage

// ----- rtl/ifcm_if.sv -----
// ifcm_req_if / ifcm_rsp_if: valid-ready channels for intensity samples and pixels
// depends on ifcm_pkg
`timescale 1ns / 1ps
interface ifcm_req_if;
   import ifcm_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [INTENSITY_W-1:0] intensity;
   modport source (output valid, output intensity, input ready);
   modport sink   (input valid, input intensity, output ready);
endinterface

interface ifcm_rsp_if;
   import ifcm_pkg::*;
   logic      valid;
   logic      ready;
   color_type red;
   color_type green;
   color_type blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/ifcm_locate.sv -----
// ifcm_locate: clamp, scale to twentieths, segment select and offset (two stages)
// depends on ifcm_pkg
`timescale 1ns / 1ps
module ifcm_locate #(
   parameter int FRAC_BITS = ifcm_pkg::INTENSITY_FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [ifcm_pkg::INTENSITY_W-1:0] in_intensity,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output ifcm_pkg::seg_idx_type                   out_seg,
   output logic [FRAC_BITS+1:0]                    out_off
);
   import ifcm_pkg::*;

   localparam int X_W   = INTENSITY_W - 1;
   localparam int CMP_W = (SCALE_W > FRAC_BITS + POS_W) ? SCALE_W : FRAC_BITS + POS_W;
   localparam int OFF_W = FRAC_BITS + 2;
   localparam logic [CMP_W-1:0] ONE = CMP_W'(1) << FRAC_BITS;

   logic [X_W-1:0]     x;
   logic [CMP_W-1:0]   x_ext;
   logic               s1_ready;
   logic               s1_valid_ff, s1_valid_in;
   logic [SCALE_W-1:0] s1_scaled_ff, s1_scaled_in;

   logic               s2_ready;
   logic               s2_valid_ff, s2_valid_in;
   seg_idx_type        s2_seg_ff, s2_seg_in;
   logic [OFF_W-1:0]   s2_off_ff, s2_off_in;
   logic [CMP_W-1:0]   scaled_ext;

   // stage 1: clamp to 0..1.0 and scale by 20
   always_comb begin
      x_ext = CMP_W'(in_intensity[X_W-1:0]);
      if (in_intensity[INTENSITY_W-1]) begin
         x = '0;
      end else if (x_ext > ONE) begin
         x = X_W'(ONE);
      end else begin
         x = in_intensity[X_W-1:0];
      end
      s1_scaled_in = (SCALE_W'(x) << 4) + (SCALE_W'(x) << 2);
      s1_ready     = !s1_valid_ff || s2_ready;
      s1_valid_in  = s1_ready ? in_valid : s1_valid_ff;
   end

   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_ready && in_valid) begin
         s1_scaled_ff <= s1_scaled_in;
      end
   end

   // stage 2: count breakpoints passed, offset into segment
   always_comb begin
      scaled_ext = CMP_W'(s1_scaled_ff);
      s2_seg_in  = '0;
      for (int k = 1; k < NUM_SEGS; k++) begin
         if (scaled_ext >= (CMP_W'(SEG_START[k]) << FRAC_BITS)) begin
            s2_seg_in = s2_seg_in + 1'b1;
         end
      end
      s2_off_in   = OFF_W'(scaled_ext - (CMP_W'(SEG_START[s2_seg_in]) << FRAC_BITS));
      s2_ready    = !s2_valid_ff || out_ready;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_seg_ff <= s2_seg_in;
         s2_off_ff <= s2_off_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_seg   = s2_seg_ff;
   assign out_off   = s2_off_ff;

endmodule

// ----- rtl/ifcm_blend.sv -----
// ifcm_blend: per-channel interpolation, slope product, rescale and width divide
// depends on ifcm_pkg; three register stages, the last one drives the result
`timescale 1ns / 1ps
module ifcm_blend #(
   parameter int FRAC_BITS = ifcm_pkg::INTENSITY_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ifcm_pkg::seg_idx_type in_seg,
   input  logic [FRAC_BITS+1:0]  in_off,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ifcm_pkg::color_type   out_color [ifcm_pkg::NUM_CH]
);
   import ifcm_pkg::*;

   localparam int OFF_W  = FRAC_BITS + 2;
   localparam int PROD_W = SLOPE_W + OFF_W + 1;

   logic                     s3_ready;
   logic                     s3_valid_ff, s3_valid_in;
   seg_idx_type              s3_seg_ff;
   logic signed [PROD_W-1:0] s3_prod_ff [NUM_CH];
   logic signed [PROD_W-1:0] s3_prod_in [NUM_CH];

   logic                     s4_ready;
   logic                     s4_valid_ff, s4_valid_in;
   seg_span_type             s4_span_ff;
   logic [BASE_SPAN_W-1:0]   s4_q_ff [NUM_CH];
   logic [BASE_SPAN_W-1:0]   s4_q_in [NUM_CH];
   logic signed [PROD_W-1:0] prod_sh [NUM_CH];
   logic signed [Q_W-1:0]    q_full [NUM_CH];

   logic                     s5_ready;
   logic                     s5_valid_ff, s5_valid_in;
   color_type                s5_color_ff [NUM_CH];
   color_type                s5_color_in [NUM_CH];
   logic [RECIP_W-1:0]       third [NUM_CH];

   // stage 3: slope times offset
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         s3_prod_in[c] = PROD_W'(SEG_SLOPE[in_seg][c]) * PROD_W'(signed'({1'b0, in_off}));
      end
      s3_ready    = !s3_valid_ff || s4_ready;
      s3_valid_in = s3_ready ? in_valid : s3_valid_ff;
   end

   assign in_ready = s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
      if (s3_ready && in_valid) begin
         s3_seg_ff  <= in_seg;
         s3_prod_ff <= s3_prod_in;
      end
   end

   // stage 4: base times width plus floored product over full scale
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         prod_sh[c] = s3_prod_ff[c] >>> FRAC_BITS;
         q_full[c]  = Q_W'(signed'({1'b0, base_scaled(s3_seg_ff, c)})) + Q_W'(prod_sh[c]);
         s4_q_in[c] = q_full[c][BASE_SPAN_W-1:0];
      end
      s4_ready    = !s4_valid_ff || s5_ready;
      s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_span_ff <= SEG_SPAN[s3_seg_ff];
         s4_q_ff    <= s4_q_in;
      end
   end

   // stage 5: divide by segment width, reciprocal multiply for three
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         third[c] = (RECIP_W'(s4_q_ff[c]) * RECIP_W'(RECIP3)) >> RECIP3_SHIFT;
         case (s4_span_ff)
            3'd1:    s5_color_in[c] = COLOR_W'(s4_q_ff[c]);
            3'd2:    s5_color_in[c] = COLOR_W'(s4_q_ff[c] >> 1);
            3'd3:    s5_color_in[c] = COLOR_W'(third[c]);
            3'd4:    s5_color_in[c] = COLOR_W'(s4_q_ff[c] >> 2);
            default: s5_color_in[c] = COLOR_W'(s4_q_ff[c]);
         endcase
      end
      s5_ready    = !s5_valid_ff || out_ready;
      s5_valid_in = s5_ready ? s4_valid_ff : s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s5_valid_in;
      end
      if (s5_ready && s4_valid_ff) begin
         s5_color_ff <= s5_color_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_color = s5_color_ff;

endmodule

// ----- rtl/intensity_false_color_map.sv -----
// intensity_false_color_map: top level, intensity sample in, false-color pixel out
// depends on ifcm_pkg, ifcm_req_if, ifcm_rsp_if, ifcm_locate, ifcm_blend
//
//   channel  direction  payload                     transaction
//   req_ch   in         intensity (16b signed)      valid && ready
//   rsp_ch   out        red, green, blue (8b each)  valid && ready
//
// one transaction per cycle when nothing stalls; five register stages, and the result
// is registered in the last one
// one stage each for clamp and scale, segment select, slope multiply, rescale
// and width divide
// reset clears the stage valid bits only
// each stage holds while the next one is full and stalled, so bubbles still fill under a stall
`timescale 1ns / 1ps
module intensity_false_color_map #(
   parameter int INTENSITY_FRAC_BITS = ifcm_pkg::INTENSITY_FRAC_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   ifcm_req_if.sink    req_ch,
   ifcm_rsp_if.source  rsp_ch
);
   import ifcm_pkg::*;

   logic                           mid_valid;
   logic                           mid_ready;
   seg_idx_type                    mid_seg;
   logic [INTENSITY_FRAC_BITS+1:0] mid_off;
   color_type                      color [NUM_CH];

   ifcm_locate #(.FRAC_BITS(INTENSITY_FRAC_BITS)) u_locate (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_ch.valid),
      .in_ready     (req_ch.ready),
      .in_intensity (req_ch.intensity),
      .out_valid    (mid_valid),
      .out_ready    (mid_ready),
      .out_seg      (mid_seg),
      .out_off      (mid_off)
   );

   ifcm_blend #(.FRAC_BITS(INTENSITY_FRAC_BITS)) u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_seg    (mid_seg),
      .in_off    (mid_off),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_color (color)
   );

   assign rsp_ch.red   = color[CH_RED];
   assign rsp_ch.green = color[CH_GREEN];
   assign rsp_ch.blue  = color[CH_BLUE];

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      mid_valid && !mid_ready |=> mid_valid && $stable(mid_seg) && $stable(mid_off))
      else $error("segment stage lost or changed a stalled transaction");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      mid_valid |-> mid_seg < SEG_W'(NUM_SEGS))
      else $error("segment index out of range");

   a_red_tint: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.red == 8'd255 |-> rsp_ch.blue <= 8'd100)
      else $error("saturated red with too much blue");

endmodule
